/* rtl/countdown_timer_list_defines.svh */
`ifndef COUNTDOWN_TIMER_LIST_DEFINES_SVH
`define COUNTDOWN_TIMER_LIST_DEFINES_SVH

// implication checked in the same cycle
`define CTL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("countdown_timer_list: assertion failed");

// implication checked in the next cycle
`define CTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("countdown_timer_list: assertion failed");

`endif

/* rtl/ctl_pkg.sv */
package ctl_pkg;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    typedef struct packed {
        logic [31:0] user;
        logic [15:0] command;
        logic [31:0] argument;
    } fired_t;

    typedef struct packed {
        fired_t      info;
        logic [15:0] remaining;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic tail;
        logic add;
    } cell_ctrl_t;

    typedef struct packed {
        logic drop;
        logic found;
        logic flush;
    } rpt_req_t;

endpackage

/* rtl/countdown_timer_list.sv */
// channel | role          | tdata (low bit up)                          | tuser       | tlast
// s_      | add / tick in | user_id, command_code, argument, delay_ticks | cmd         | -
// m_      | reports out   | fired_user, fired_command, fired_argument    | report_kind | last_of_run
//
// Add: an add to a full table yields one report.
// Tick: the cell row rotates once per live entry, one entry per cycle through cell 0 while
// m_ is not stalled, then passes through the flush state.
// Reports leave at one per cycle; a stalled m_ holds the row until a slot frees.
// Reset clears occupancy and the report stage; timer entries are undefined until written.
`include "countdown_timer_list_defines.svh"

module countdown_timer_list #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // user_id, command_code, argument, delay_ticks
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // fired_user, fired_command, fired_argument
    output logic        m_tuser,   // report_kind
    output logic        m_tlast    // last_of_run
);

    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] steps_reg, steps_next;

    logic                 out_free;
    logic                 pend_valid;
    logic                 s_accept;
    logic                 add_write;
    logic                 step;
    logic                 expire;
    ctl_pkg::rpt_req_t    rpt_req;
    ctl_pkg::entry_t      add_entry;
    ctl_pkg::entry_t      tail_entry;
    ctl_pkg::entry_t      cells [TIMER_SLOTS];
    ctl_pkg::cell_ctrl_t  cell_ctrl [TIMER_SLOTS];

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign add_entry.info.user     = s_tdata[31:0];
    assign add_entry.info.command  = s_tdata[47:32];
    assign add_entry.info.argument = s_tdata[79:48];
    assign add_entry.remaining     = s_tdata[95:80];

    assign add_write = s_accept && (s_tuser == ctl_pkg::CMD_ADD)
                       && (occ_reg != CNT_W'(TIMER_SLOTS));

    assign step   = (state_reg == ST_SCAN) && out_free;
    assign expire = cells[0].remaining <= 16'd1;

    assign tail_entry.info      = cells[0].info;
    assign tail_entry.remaining = cells[0].remaining - 16'd1;

    assign rpt_req.drop  = s_accept && (s_tuser == ctl_pkg::CMD_ADD)
                           && (occ_reg == CNT_W'(TIMER_SLOTS));
    assign rpt_req.found = step && expire;
    assign rpt_req.flush = (state_reg == ST_FLUSH) && pend_valid && out_free;

    always_comb begin
        state_next = state_reg;
        occ_next   = occ_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (add_write) begin
                    occ_next = occ_reg + CNT_W'(1);
                end else if (s_accept && (s_tuser == ctl_pkg::CMD_TICK)
                             && (occ_reg != '0)) begin
                    steps_next = occ_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step) begin
                    steps_next = steps_reg - CNT_W'(1);
                    if (expire) begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                    if (steps_reg == CNT_W'(1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            steps_reg <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            steps_reg <= steps_next;
        end
    end

    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        ctl_pkg::entry_t neighbor;

        if (i == TIMER_SLOTS - 1) begin : g_end
            assign neighbor = cells[i];
        end else begin : g_mid
            assign neighbor = cells[i+1];
        end

        assign cell_ctrl[i].shift = step && (CNT_W'(i + 1) < occ_reg);
        assign cell_ctrl[i].tail  = step && !expire && (CNT_W'(i + 1) == occ_reg);
        assign cell_ctrl[i].add   = add_write && (CNT_W'(i) == occ_reg);

        ctl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .neighbor   (neighbor),
            .tail_entry (tail_entry),
            .add_entry  (add_entry),
            .entry      (cells[i])
        );
    end

    ctl_report u_report (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (rpt_req),
        .head_info  (cells[0].info),
        .add_info   (add_entry.info),
        .out_free   (out_free),
        .pend_valid (pend_valid),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    `CTL_ASSERT_NOW(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= CNT_W'(TIMER_SLOTS))
    `CTL_ASSERT_NOW(a_scan_steps, aclk, aresetn, state_reg == ST_SCAN, steps_reg != '0)
    `CTL_ASSERT_NOW(a_flush_pend, aclk, aresetn, rpt_req.flush, pend_valid)
    `CTL_ASSERT_NOW(a_req_room, aclk, aresetn,
                    rpt_req.drop || rpt_req.found || rpt_req.flush, out_free)
    `CTL_ASSERT_NEXT(a_idle_no_pend, aclk, aresetn,
                     (state_reg == ST_FLUSH) && (state_next == ST_IDLE), !pend_valid)

endmodule

/* rtl/ctl_cell.sv */
module ctl_cell (
    input  logic               aclk,
    input  ctl_pkg::cell_ctrl_t ctrl,
    input  ctl_pkg::entry_t    neighbor,
    input  ctl_pkg::entry_t    tail_entry,
    input  ctl_pkg::entry_t    add_entry,
    output ctl_pkg::entry_t    entry
);

    ctl_pkg::entry_t entry_reg;
    ctl_pkg::entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.add) begin
            entry_next = add_entry;
        end else if (ctrl.shift) begin
            entry_next = neighbor;
        end else if (ctrl.tail) begin
            entry_next = tail_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* rtl/ctl_report.sv */
module ctl_report (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctl_pkg::rpt_req_t req,
    input  ctl_pkg::fired_t   head_info,
    input  ctl_pkg::fired_t   add_info,
    output logic              out_free,
    output logic              pend_valid,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,   // fired_user, fired_command, fired_argument
    output logic              m_tuser,   // report_kind
    output logic              m_tlast    // last_of_run
);

    logic            valid_reg, valid_next;
    logic            pend_reg, pend_next;
    ctl_pkg::fired_t pend_info_reg, pend_info_next;
    ctl_pkg::fired_t out_info_reg, out_info_next;
    logic            kind_reg, kind_next;
    logic            last_reg, last_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        pend_info_next = pend_info_reg;
        out_info_next  = out_info_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (req.drop) begin
            valid_next    = 1'b1;
            out_info_next = add_info;
            kind_next     = ctl_pkg::KIND_DROPPED;
            last_next     = 1'b1;
        end else if (req.found) begin
            if (pend_reg) begin
                valid_next    = 1'b1;
                out_info_next = pend_info_reg;
                kind_next     = ctl_pkg::KIND_EXPIRED;
                last_next     = 1'b0;
            end
            pend_next      = 1'b1;
            pend_info_next = head_info;
        end else if (req.flush) begin
            valid_next    = 1'b1;
            out_info_next = pend_info_reg;
            kind_next     = ctl_pkg::KIND_EXPIRED;
            last_next     = 1'b1;
            pend_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
        pend_info_reg <= pend_info_next;
        out_info_reg  <= out_info_next;
        kind_reg      <= kind_next;
        last_reg      <= last_next;
    end

    assign pend_valid = pend_reg;
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {out_info_reg.argument, out_info_reg.command, out_info_reg.user};
    assign m_tuser    = kind_reg;
    assign m_tlast    = last_reg;

endmodule
